// ----- rtl/gsfa_pkg.sv -----
// Shared types, codes and defaults for the grid slot fit allocator.
`timescale 1ns / 1ps

package gsfa_pkg;

  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 8;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;
  localparam int FIELD_W  = 3;
  localparam int SIZE_W   = 2;
  localparam int LIDX_W   = 12;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gsfa_state_t;

  typedef struct packed {
    logic clear_wr;
    logic step;
    logic scan_rd;
    logic load_wr;
    logic start;
    logic finish;
  } gsfa_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_busy;
  } gsfa_sts_t;

endpackage

// ----- rtl/gsfa_ctrl.sv -----
// Controller state machine that sequences clearing, loads, scans and result hand-off.
`timescale 1ns / 1ps

module gsfa_ctrl
  import gsfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tuser,
  output logic      s_tready,
  input  gsfa_sts_t sts,
  output gsfa_cmd_t cmd
);

  gsfa_state_t state;
  gsfa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.step     = 1'b1;
        if (sts.addr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == REQ_ALLOC) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step    = 1'b1;
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/gsfa_dp.sv -----
// Datapath with the slot memories, scan counters, fit comparison and output register.
`timescale 1ns / 1ps

module gsfa_dp
  import gsfa_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                clk,
  input  logic                rst,
  input  gsfa_cmd_t           cmd,
  output gsfa_sts_t           sts,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_wdata,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser
);

  localparam int NSLOTS = ROWS * COLS;
  localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;

  logic [SIZE_W-1:0] size_mem  [NSLOTS];
  logic              taken_mem [NSLOTS];

  logic [1:0]         fit_policy;
  logic [AW-1:0]      scan_addr;
  logic [RW-1:0]      scan_row;
  logic [CW-1:0]      scan_col;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_taken;
  logic               cmp_valid;
  logic [AW-1:0]      cmp_addr;
  logic [FIELD_W-1:0] cmp_row;
  logic [FIELD_W-1:0] cmp_col;
  logic [SIZE_W-1:0]  need;
  logic               found;
  logic [AW-1:0]      pick_addr;
  logic [FIELD_W-1:0] pick_row;
  logic [FIELD_W-1:0] pick_col;
  logic [SIZE_W-1:0]  pick_size;

  logic [FIELD_W-1:0] load_row;
  logic [FIELD_W-1:0] load_col;
  logic [SIZE_W-1:0]  load_size_raw;
  logic [SIZE_W-1:0]  load_size;
  logic               load_taken;
  logic               load_in_grid;
  logic [LIDX_W-1:0]  load_idx;
  logic [AW-1:0]      load_addr;
  logic               cand;
  logic               take;

  assign load_row      = s_tdata[2:0];
  assign load_col      = s_tdata[5:3];
  assign load_size_raw = s_tdata[7:6];
  assign load_taken    = s_tdata[8];
  assign load_size     = (load_size_raw > SIZE_MAX) ? SIZE_MAX : load_size_raw;
  assign load_in_grid  = (32'(load_row) < ROWS) && (32'(load_col) < COLS);
  assign load_idx      = LIDX_W'(load_row) * LIDX_W'(COLS) + LIDX_W'(load_col);
  assign load_addr     = AW'(load_idx);

  assign sts.addr_last = (32'(scan_addr) == NSLOTS - 1);
  assign sts.out_busy  = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
    end else if (cfg_wen) begin
      fit_policy <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      scan_row  <= '0;
      scan_col  <= '0;
    end else if (cmd.start || (cmd.step && sts.addr_last)) begin
      scan_addr <= '0;
      scan_row  <= '0;
      scan_col  <= '0;
    end else if (cmd.step) begin
      scan_addr <= scan_addr + 1'b1;
      if (32'(scan_col) == COLS - 1) begin
        scan_col <= '0;
        scan_row <= scan_row + 1'b1;
      end else begin
        scan_col <= scan_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      taken_mem[scan_addr] <= 1'b1;
    end else if (cmd.load_wr && load_in_grid) begin
      taken_mem[load_addr] <= load_taken;
      size_mem[load_addr]  <= load_size;
    end else if (cmd.finish && found) begin
      taken_mem[pick_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_size  <= size_mem[scan_addr];
    rd_taken <= taken_mem[scan_addr];
    cmp_addr <= scan_addr;
    cmp_row  <= FIELD_W'(scan_row);
    cmp_col  <= FIELD_W'(scan_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_rd;
    end
  end

  assign cand = cmp_valid && !rd_taken && (rd_size >= need);
  assign take = cand && (!found
                         || ((fit_policy == POL_BEST) && (rd_size < pick_size))
                         || ((fit_policy == POL_WORST) && (rd_size > pick_size)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      need <= s_tdata[10:9];
    end
    if (take) begin
      pick_addr <= cmp_addr;
      pick_row  <= cmp_row;
      pick_col  <= cmp_col;
      pick_size <= rd_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser <= found;
      if (found) begin
        m_tdata <= {2'b00, pick_col, pick_row};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// ----- rtl/grid_slot_fit_allocator.sv -----
// Top level of the grid slot fit allocator.
// A load transaction does not stall; the next transaction is accepted in the following cycle.
// A request transaction scans every slot once, one slot a cycle through the memory read port:
// its result is registered from DONE after a DRAIN state; DONE waits while an earlier result is
// stalled, then the next transaction is taken. After reset the occupied marks are set in one
// pass over all slots, with no transaction accepted; the fit policy resets to first fit.
`timescale 1ns / 1ps

module grid_slot_fit_allocator
  import gsfa_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_wdata,  // fit_policy
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,    // load_row, load_col, load_size, load_taken,
                                          // request_size, zero fill
  input  logic                s_tuser,    // req_type
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,    // grant_row, grant_col, zero fill
  output logic                m_tuser     // granted
);

  gsfa_cmd_t cmd;
  gsfa_sts_t sts;

  gsfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsfa_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/gsfa_chk.sv -----
// Port-level checker for the grid slot fit allocator and its bind statement.
`timescale 1ns / 1ps

module gsfa_chk
  import gsfa_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("refused result carries a nonzero slot");

  a_grant_in_grid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (32'(m_tdata[2:0]) < ROWS) && (32'(m_tdata[5:3]) < COLS))
    else $error("granted slot outside the grid");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("load transaction produced a result");

  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_ALLOC) |=> !s_tready)
    else $error("input accepted during a scan");

endmodule

bind grid_slot_fit_allocator gsfa_chk #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_gsfa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
